[sv/osc_pkg.sv]
// ----------------------------------------------------------------------------
// osc_pkg: shared types and constants for opacity step correction
// Payload structs, the stage tag and the exp2 coefficient function.
// ----------------------------------------------------------------------------
package osc_pkg;

   localparam int LOG_FRAC  = 24;
   localparam int MANT_FRAC = 30;
   localparam logic [15:0] STEP_RESET = 16'd256;

   typedef struct packed {
      logic [15:0] alpha;
      logic        last_entry;
   } req_type;

   typedef struct packed {
      logic [15:0] corrected_alpha;
      logic        last_out;
   } rsp_type;

   // control that travels with each pipeline stage
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        bypass;
      logic [15:0] alpha;
   } tag_type;

   // integer square root, elaboration time only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bits;
      logic [63:0] rem;
      res = '0;
      rem = v;
      for (int i = 0; i < 32; i++) begin
         bits = 64'd1 << (62 - 2 * i);
         if (rem >= res + bits) begin
            rem = rem - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // 2^-(2^-(j+1)) in q0.30
   function automatic logic [63:0] exp_coef(input int j);
      logic [63:0] c;
      c = isqrt64(64'd1 << (2 * MANT_FRAC - 1));
      for (int i = 0; i < j; i++) begin
         c = isqrt64(c << MANT_FRAC);
      end
      return c;
   endfunction

endpackage

[sv/osc_log2.sv]
// ----------------------------------------------------------------------------
// osc_log2: pipelined log2 magnitude
// Normalizes x, then one squaring per stage yields 24 fraction bits.
// ----------------------------------------------------------------------------
module osc_log2
   import osc_pkg::*;
#(
   parameter int ALPHA_BITS = 16,
   localparam int EA_W = $clog2(ALPHA_BITS + 1),
   localparam int MAG_W = EA_W + LOG_FRAC
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  tag_type               tag_in,
   input  logic [ALPHA_BITS-1:0] x_in,
   output tag_type               tag_out,
   output logic [MAG_W-1:0]      mag_out
);

   localparam int LEAD_W = $clog2(ALPHA_BITS);

   logic [LEAD_W-1:0] lead;
   logic [4:0]        shamt;
   logic [30:0]       norm;
   logic [EA_W-1:0]   ea;

   tag_type               tag_ff [0:LOG_FRAC];
   logic [30:0]           m_ff   [0:LOG_FRAC];
   logic [LOG_FRAC-1:0]   f_ff   [0:LOG_FRAC];
   logic [EA_W-1:0]       ea_ff  [0:LOG_FRAC];
   tag_type               tag_out_ff;
   logic [MAG_W-1:0]      mag_ff;

   // leading one of x
   always_comb begin
      lead = '0;
      for (int i = 0; i < ALPHA_BITS; i++) begin
         if (x_in[i]) begin
            lead = LEAD_W'(i);
         end
      end
   end

   assign shamt = 5'(MANT_FRAC - int'(lead));
   assign norm  = 31'(x_in) << shamt;
   assign ea    = EA_W'(ALPHA_BITS - int'(lead));

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (adv) begin
         tag_ff[0] <= tag_in;
         m_ff[0]   <= norm;
         f_ff[0]   <= '0;
         ea_ff[0]  <= ea;
      end
   end

   for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = 62'(m_ff[i-1]) * 62'(m_ff[i-1]);
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (adv) begin
            tag_ff[i] <= tag_ff[i-1];
            m_ff[i]   <= t[31] ? t[31:1] : t[30:0];
            f_ff[i]   <= {f_ff[i-1][LOG_FRAC-2:0], t[31]};
            ea_ff[i]  <= ea_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out_ff <= '0;
      end else if (adv) begin
         tag_out_ff <= tag_ff[LOG_FRAC];
         mag_ff     <= {ea_ff[LOG_FRAC], LOG_FRAC'(0)} - MAG_W'(f_ff[LOG_FRAC]);
      end
   end

   assign tag_out = tag_out_ff;
   assign mag_out = mag_ff;

endmodule

[sv/osc_exp2.sv]
// ----------------------------------------------------------------------------
// osc_exp2: pipelined exp2 of a negative power
// One constant multiply per fraction bit, then a rounding shift by k.
// ----------------------------------------------------------------------------
module osc_exp2
   import osc_pkg::*;
#(
   parameter int ALPHA_BITS = 16,
   parameter int K_W = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  tag_type             tag_in,
   input  logic [LOG_FRAC-1:0] r_in,
   input  logic [K_W-1:0]      k_in,
   output tag_type             tag_out,
   output logic [30:0]         y_out
);

   tag_type             tag_ff [1:LOG_FRAC];
   logic [30:0]         y_ff   [1:LOG_FRAC];
   logic [LOG_FRAC-1:0] r_ff   [1:LOG_FRAC];
   logic [K_W-1:0]      k_ff   [1:LOG_FRAC];
   tag_type             tag_out_ff;
   logic [30:0]         y_out_ff;

   for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_mul
      localparam logic [29:0] COEF = 30'(exp_coef(j - 1));
      tag_type             tag_prev;
      logic [30:0]         y_prev;
      logic [LOG_FRAC-1:0] r_prev;
      logic [K_W-1:0]      k_prev;
      logic [61:0]         prod;
      if (j == 1) begin : g_first
         assign tag_prev = tag_in;
         assign y_prev   = 31'(1) << MANT_FRAC;
         assign r_prev   = r_in;
         assign k_prev   = k_in;
      end else begin : g_next
         assign tag_prev = tag_ff[j-1];
         assign y_prev   = y_ff[j-1];
         assign r_prev   = r_ff[j-1];
         assign k_prev   = k_ff[j-1];
      end
      assign prod = 62'(y_prev) * 62'(COEF) + (62'(1) << (MANT_FRAC - 1));
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j] <= '0;
         end else if (adv) begin
            tag_ff[j] <= tag_prev;
            y_ff[j]   <= r_prev[LOG_FRAC-j] ? prod[60:30] : y_prev;
            r_ff[j]   <= r_prev;
            k_ff[j]   <= k_prev;
         end
      end
   end

   // rounding shift by k + 30 - alpha bits, nothing survives at 32 or more
   logic [K_W-1:0] k_last;
   logic [4:0]     sh;
   logic [31:0]    rnd;
   logic [31:0]    shifted;

   assign k_last  = k_ff[LOG_FRAC];
   assign sh      = 5'(k_last) + 5'(MANT_FRAC - ALPHA_BITS);
   assign rnd     = 32'(y_ff[LOG_FRAC]) + (32'(1) << (sh - 5'd1));
   assign shifted = rnd >> sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out_ff <= '0;
      end else if (adv) begin
         tag_out_ff <= tag_ff[LOG_FRAC];
         y_out_ff   <= (k_last >= K_W'(ALPHA_BITS + 2)) ? '0 : shifted[30:0];
      end
   end

   assign tag_out = tag_out_ff;
   assign y_out   = y_out_ff;

endmodule

[sv/opacity_step_correction_top.sv]
// ----------------------------------------------------------------------------
// opacity_step_correction_top: opacity correction for ray sample step
// Streams opacity table entries and returns 1-(1-alpha)^step per entry.
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per table entry (alpha q0.16, last flag)
//   rsp channel: one transaction per entry, corrected alpha and the flag
//   csr port: csr_we writes step_size (q8.8); only while idle, not enforced
// pipeline from req acceptance to rsp_valid:
//   1 input stage, 26 log2 stages (normalize, 24 squarings, subtract),
//   1 step multiply, 25 exp2 stages (24 multiplies, shift), 1 output reg
// throughput: one transaction per cycle unless stalled, set by the
//   one-squaring and one-multiply-per-stage pipeline
// reset: clears all stage valid bits and rsp_valid, step_size = 1.0
// stall: when rsp holds a result and rsp_ready is low, every stage
//   freezes and req_ready drops; nothing is lost or repeated
// entries at or below 6/65536 (about 0.00009) pass through unchanged
// ----------------------------------------------------------------------------
module opacity_step_correction_top
   import osc_pkg::*;
#(
   parameter int ALPHA_BITS = 16,
   parameter int STEP_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int ALPHA_MIN = (1 << ALPHA_BITS) / 10000;
   localparam int EA_W  = $clog2(ALPHA_BITS + 1);
   localparam int MAG_W = EA_W + LOG_FRAC;
   localparam int PR_W  = MAG_W + 16;
   localparam int P_W   = PR_W - STEP_FRAC_BITS;
   localparam int K_W   = P_W - LOG_FRAC;

   // whole pipeline moves unless the output holds an untaken transaction
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // step size register
   logic [15:0] step_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_we) begin
         step_ff <= csr_wdata;
      end
   end

   // input stage: keep the low alpha bits and flag small entries
   logic [ALPHA_BITS-1:0] a_in;
   tag_type               tag_in;
   tag_type               req_tag_ff;
   logic [ALPHA_BITS-1:0] a_ff;
   logic [ALPHA_BITS-1:0] x;

   assign a_in          = ALPHA_BITS'(req_payload.alpha);
   assign tag_in.valid  = req_valid;
   assign tag_in.last   = req_payload.last_entry;
   assign tag_in.bypass = (a_in <= ALPHA_BITS'(ALPHA_MIN));
   assign tag_in.alpha  = 16'(a_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_tag_ff <= '0;
      end else if (adv) begin
         req_tag_ff <= tag_in;
         a_ff       <= a_in;
      end
   end

   // 1 - alpha in q0.A, wraps only for bypassed entries
   assign x = (~a_ff) + ALPHA_BITS'(1);

   tag_type          log_tag;
   logic [MAG_W-1:0] mag;

   osc_log2 #(
      .ALPHA_BITS (ALPHA_BITS)
   ) u_log2 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .tag_in  (req_tag_ff),
      .x_in    (x),
      .tag_out (log_tag),
      .mag_out (mag)
   );

   // scale the log magnitude by the step, rounded
   logic [PR_W-1:0] prod;
   tag_type         p_tag_ff;
   logic [P_W-1:0]  p_ff;

   assign prod = PR_W'(mag) * PR_W'(step_ff) + (PR_W'(1) << (STEP_FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         p_tag_ff <= '0;
      end else if (adv) begin
         p_tag_ff <= log_tag;
         p_ff     <= prod[PR_W-1:STEP_FRAC_BITS];
      end
   end

   tag_type     exp_tag;
   logic [30:0] y;

   osc_exp2 #(
      .ALPHA_BITS (ALPHA_BITS),
      .K_W        (K_W)
   ) u_exp2 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .tag_in  (p_tag_ff),
      .r_in    (p_ff[LOG_FRAC-1:0]),
      .k_in    (p_ff[P_W-1:LOG_FRAC]),
      .tag_out (exp_tag),
      .y_out   (y)
   );

   // 1 - y with saturation, or the untouched small entry
   logic [ALPHA_BITS:0]   diff;
   logic [ALPHA_BITS-1:0] res;

   assign diff = {1'b1, ALPHA_BITS'(0)} - (ALPHA_BITS + 1)'(y);

   always_comb begin
      if (exp_tag.bypass) begin
         res = ALPHA_BITS'(exp_tag.alpha);
      end else if (y >= (31'(1) << ALPHA_BITS)) begin
         res = '0;
      end else if (y == '0) begin
         res = '1;
      end else begin
         res = diff[ALPHA_BITS-1:0];
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff           <= exp_tag.valid;
         rsp_ff.corrected_alpha <= 16'(res);
         rsp_ff.last_out        <= exp_tag.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
